>>> hw/rtl/keyed_slot_registry_top_defines.svh
// ----------------------------------------------------------------------------
// keyed_slot_registry_top_defines
// Assertion macros used by the keyed slot registry top level.
// ----------------------------------------------------------------------------
`ifndef KEYED_SLOT_REGISTRY_TOP_DEFINES_SVH
`define KEYED_SLOT_REGISTRY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ksr_pkg.sv
// ----------------------------------------------------------------------------
// ksr_pkg
// Types, codes and helpers of the keyed slot registry.
// ----------------------------------------------------------------------------
package ksr_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned ACT_W    = 7;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CTR_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // request opcodes
  localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP        = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key_high;
    logic [KEY_W-1:0]    key_low;
    logic [HANDLE_W-1:0] handle;
  } ksr_entry_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key_high;
    logic [KEY_W-1:0]    key_low;
    logic [HANDLE_W-1:0] entry_handle;
  } ksr_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [SLOT_W-1:0]   slot_index;
    logic [HANDLE_W-1:0] found_handle;
    logic [ACT_W-1:0]    active_count;
    logic [CTR_W-1:0]    reg_count;
    logic [CTR_W-1:0]    lookup_count;
    logic [CTR_W-1:0]    hit_count;
    logic [CTR_W-1:0]    miss_count;
  } ksr_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // item accepted, load it
    logic clr_wr;  // clearing pass write
    logic issue;   // scan read at the current address
    logic latch;   // capture the matching slot
    logic commit;  // apply the item and load the result register
  } ksr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic direct;      // item resolves without a scan
    logic issue_done;
    logic rd_pend;
    logic hit;
    logic out_free;
  } ksr_sts_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    return (v == '1) ? v : v + CTR_W'(1);
  endfunction

endpackage

>>> hw/rtl/ksr_req_if.sv
// ----------------------------------------------------------------------------
// ksr_req_if
// Request channel of the keyed slot registry: valid/ready plus one item.
// ----------------------------------------------------------------------------
interface ksr_req_if;
  logic                            valid;
  logic                            ready;
  logic [ksr_pkg::OP_W-1:0]        op;
  logic [ksr_pkg::KEY_W-1:0]       key_high;
  logic [ksr_pkg::KEY_W-1:0]       key_low;
  logic [ksr_pkg::HANDLE_W-1:0]    entry_handle;

  modport source (output valid, output op, output key_high, output key_low,
                  output entry_handle, input ready);
  modport sink   (input valid, input op, input key_high, input key_low,
                  input entry_handle, output ready);
endinterface

>>> hw/rtl/ksr_rsp_if.sv
// ----------------------------------------------------------------------------
// ksr_rsp_if
// Result channel of the keyed slot registry: valid/ready plus one item.
// ----------------------------------------------------------------------------
interface ksr_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ksr_pkg::STAT_W-1:0]      status;
  logic [ksr_pkg::SLOT_W-1:0]      slot_index;
  logic [ksr_pkg::HANDLE_W-1:0]    found_handle;
  logic [ksr_pkg::ACT_W-1:0]       active_count;
  logic [ksr_pkg::CTR_W-1:0]       reg_count;
  logic [ksr_pkg::CTR_W-1:0]       lookup_count;
  logic [ksr_pkg::CTR_W-1:0]       hit_count;
  logic [ksr_pkg::CTR_W-1:0]       miss_count;

  modport source (output valid, output status, output slot_index, output found_handle,
                  output active_count, output reg_count, output lookup_count,
                  output hit_count, output miss_count, input ready);
  modport sink   (input valid, input status, input slot_index, input found_handle,
                  input active_count, input reg_count, input lookup_count,
                  input hit_count, input miss_count, output ready);
endinterface

>>> hw/rtl/ksr_ctrl.sv
// ----------------------------------------------------------------------------
// ksr_ctrl
// Sequencer of the registry: clearing pass, accept, slot scan, commit.
// ----------------------------------------------------------------------------
module ksr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  ksr_pkg::ksr_sts_t sts_i,
  output ksr_pkg::ksr_cmd_t cmd_o
);

  localparam int unsigned STATE_W = 2;
  localparam logic [STATE_W-1:0] S_CLEAR = 2'd0;
  localparam logic [STATE_W-1:0] S_IDLE  = 2'd1;
  localparam logic [STATE_W-1:0] S_SCAN  = 2'd2;
  localparam logic [STATE_W-1:0] S_FIN   = 2'd3;

  logic [STATE_W-1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.direct ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = !sts_i.issue_done;
        if (sts_i.hit) begin
          cmd_o.latch = 1'b1;
          state_d     = S_FIN;
        end else if (!sts_i.rd_pend && sts_i.issue_done) begin
          // every read returned without a match
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/ksr_dpath.sv
// ----------------------------------------------------------------------------
// ksr_dpath
// Slot memory, scan address and read pipe, counters and result register.
// ----------------------------------------------------------------------------
module ksr_dpath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ksr_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  ksr_pkg::ksr_req_t            req_i,
  input  ksr_pkg::ksr_cmd_t            cmd_i,
  output ksr_pkg::ksr_sts_t            sts_o,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output ksr_pkg::ksr_rsp_t            rsp_o
);

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CAP_W  = ksr_pkg::CAP_W;
  localparam int unsigned LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned SLOT_W = ksr_pkg::SLOT_W;
  localparam int unsigned ACT_W  = ksr_pkg::ACT_W;
  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);

  ksr_pkg::ksr_entry_t slot_mem [TABLE_DEPTH];

  logic [CAP_W-1:0]          cap_q;
  logic [LIM_W-1:0]          cap_ext;
  logic [CNT_W-1:0]          cap_eff;
  logic [CNT_W-1:0]          addr_q, limit_q;
  logic [IDX_W-1:0]          addr_idx;
  ksr_pkg::ksr_req_t         req_q;
  logic                      found_q;
  logic [IDX_W-1:0]          match_idx_q;
  ksr_pkg::ksr_entry_t       match_ent_q;
  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_idx_q;
  ksr_pkg::ksr_entry_t       rd_ent_q;
  logic                      key_match;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [ksr_pkg::CTR_W-1:0] reg_q, reg_d, lkp_q, lkp_d, hit_q, hit_d, miss_q, miss_d;
  logic                      out_valid_q;
  ksr_pkg::ksr_rsp_t         rsp_q, rsp_d;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  ksr_pkg::ksr_entry_t       mem_wdata;

  // capacity above the depth acts as the depth
  assign cap_ext  = LIM_W'(cap_q);
  assign cap_eff  = (cap_ext > DEPTH_L) ? DEPTH_C : CNT_W'(cap_ext);
  assign addr_idx = addr_q[IDX_W-1:0];

  assign key_match = rd_ent_q.valid && (rd_ent_q.key_high == req_q.key_high)
                     && (rd_ent_q.key_low == req_q.key_low);

  always_comb begin
    sts_o            = '0;
    sts_o.clear_last = (addr_q == LAST_C);
    sts_o.direct     = ((req_i.op == ksr_pkg::OP_REGISTER) && (cnt_q >= cap_eff))
                       || (req_i.op == ksr_pkg::OP_NOP);
    sts_o.issue_done = (addr_q >= limit_q);
    sts_o.rd_pend    = rd_vld_q;
    // a register scan looks for a free slot, the others for a valid key match
    sts_o.hit        = rd_vld_q && ((req_q.op == ksr_pkg::OP_REGISTER) ? !rd_ent_q.valid
                                                                       : key_match);
    sts_o.out_free   = !out_valid_q || rsp_ready_i;
  end

  always_comb begin
    cnt_d     = cnt_q;
    reg_d     = reg_q;
    lkp_d     = lkp_q;
    hit_d     = hit_q;
    miss_d    = miss_q;
    rsp_d     = '0;
    mem_we    = 1'b0;
    mem_waddr = addr_idx;
    mem_wdata = '0;
    rsp_d.status = ksr_pkg::STAT_OK;
    if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
    end
    if (cmd_i.commit) begin
      mem_waddr = match_idx_q;
      case (req_q.op)
        ksr_pkg::OP_REGISTER: begin
          if (found_q) begin
            mem_we             = 1'b1;
            mem_wdata.valid    = 1'b1;
            mem_wdata.key_high = req_q.key_high;
            mem_wdata.key_low  = req_q.key_low;
            mem_wdata.handle   = req_q.entry_handle;
            cnt_d              = cnt_q + CNT_W'(1);
            reg_d              = ksr_pkg::sat_inc(reg_q);
            rsp_d.slot_index   = SLOT_W'(match_idx_q);
          end else begin
            rsp_d.status = ksr_pkg::STAT_FULL;
          end
        end
        ksr_pkg::OP_UNREGISTER: begin
          if (found_q) begin
            mem_we           = 1'b1;
            mem_wdata        = match_ent_q;
            mem_wdata.valid  = 1'b0;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
            rsp_d.slot_index = SLOT_W'(match_idx_q);
          end else begin
            rsp_d.status = ksr_pkg::STAT_NOT_FOUND;
          end
        end
        ksr_pkg::OP_LOOKUP: begin
          lkp_d = ksr_pkg::sat_inc(lkp_q);
          if (found_q) begin
            hit_d              = ksr_pkg::sat_inc(hit_q);
            rsp_d.slot_index   = SLOT_W'(match_idx_q);
            rsp_d.found_handle = match_ent_q.handle;
          end else begin
            miss_d       = ksr_pkg::sat_inc(miss_q);
            rsp_d.status = ksr_pkg::STAT_NOT_FOUND;
          end
        end
        default: begin
          rsp_d.status = ksr_pkg::STAT_OK;
        end
      endcase
    end
    rsp_d.active_count = ACT_W'(cnt_d);
    rsp_d.reg_count    = reg_d;
    rsp_d.lookup_count = lkp_d;
    rsp_d.hit_count    = hit_d;
    rsp_d.miss_count   = miss_d;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.issue) begin
      rd_ent_q <= slot_mem[addr_idx];
      rd_idx_q <= addr_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q   <= req_i;
      limit_q <= (req_i.op == ksr_pkg::OP_REGISTER) ? cap_eff : DEPTH_C;
    end
    if (cmd_i.latch) begin
      match_idx_q <= rd_idx_q;
      match_ent_q <= rd_ent_q;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= ksr_pkg::CAP_RESET;
      addr_q      <= '0;
      found_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
      reg_q       <= '0;
      lkp_q       <= '0;
      hit_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        addr_q <= '0;
      end else if (cmd_i.clr_wr || cmd_i.issue) begin
        addr_q <= addr_q + CNT_W'(1);
      end
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (cmd_i.latch) begin
        found_q <= 1'b1;
      end
      rd_vld_q <= cmd_i.issue;
      cnt_q    <= cnt_d;
      reg_q    <= reg_d;
      lkp_q    <= lkp_d;
      hit_q    <= hit_d;
      miss_q   <= miss_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> hw/rtl/keyed_slot_registry_top.sv
// ----------------------------------------------------------------------------
// keyed_slot_registry_top
// Associative table of TABLE_DEPTH keyed slots with register, unregister and
// lookup requests, searched by a linear scan of the slot memory.
// ----------------------------------------------------------------------------
// One item is worked at a time. The slot memory has one read port, so the scan
// reads one slot per cycle from slot 0 up: a request that hits slot k (for a
// register request, the lowest free slot) ends its scan there, and a lookup or
// unregister that misses reads every slot before its result. A register request
// once the active count has reached the capacity, and the unused opcode, skip
// the scan and go straight to the commit. A finished result sits in an output
// register, so the next item is taken while it waits; only the commit of that
// next item stalls until the result is taken. After reset a clearing pass writes
// every slot invalid before the first item is taken; capacity writes are accepted
// throughout.
`include "keyed_slot_registry_top_defines.svh"

module keyed_slot_registry_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ksr_pkg::CAP_W-1:0] cfg_wdata_i,
  ksr_req_if.sink                   req_i,
  ksr_rsp_if.source                 rsp_o
);

  ksr_pkg::ksr_cmd_t cmd;
  ksr_pkg::ksr_sts_t sts;
  ksr_pkg::ksr_req_t req;
  ksr_pkg::ksr_rsp_t rsp;
  logic              rsp_valid;

  assign req.op           = req_i.op;
  assign req.key_high     = req_i.key_high;
  assign req.key_low      = req_i.key_low;
  assign req.entry_handle = req_i.entry_handle;

  ksr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ksr_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.status       = rsp.status;
  assign rsp_o.slot_index   = rsp.slot_index;
  assign rsp_o.found_handle = rsp.found_handle;
  assign rsp_o.active_count = rsp.active_count;
  assign rsp_o.reg_count    = rsp.reg_count;
  assign rsp_o.lookup_count = rsp.lookup_count;
  assign rsp_o.hit_count    = rsp.hit_count;
  assign rsp_o.miss_count   = rsp.miss_count;

  `KSR_ASSERT_NOW(a_clear_blocks_req, cmd.clr_wr, !req_i.ready, "item taken during clear pass")
  `KSR_ASSERT_NEXT(a_one_item, cmd.start, !req_i.ready, "second item taken while one in flight")
  `KSR_ASSERT_NOW(a_commit_free, cmd.commit, sts.out_free, "result overwritten before taken")

endmodule
